>>> rtl/lsf_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// lsf_pkg
// Shared types and fixed field widths for the lattice shape factor table
// block: item codes, load targets and the control word carried down the pipe.
// ============================================================================
package lsf_pkg;

    localparam int Q_W            = 32;   // Q8.24 vector components and coefficients
    localparam int ENTRY_W        = 24;   // Q10.14 table entries
    localparam int IDX_W          = 12;   // entry_index field
    localparam int IDX_EXT_W      = 17;   // holds any table depth up to 65536
    localparam int FRAC_W         = 48;   // fraction bits of a Q18.48 projection
    localparam int WEIGHT_W       = 16;   // interpolation weight, 1.0 = 65536
    localparam int PROD_W         = 64;   // one Q8.24 x Q8.24 product
    localparam int SUM_W          = 66;   // sum of three products
    localparam int AXES           = 3;
    localparam int MATRIX_COEFFS  = 9;
    localparam int MAT_IDX_W      = 4;
    localparam int RESULT_W       = 64;   // Q30.34 result
    localparam int OUT_FIFO_DEPTH = 16;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_EVAL = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        SEL_A      = 2'd0,
        SEL_B      = 2'd1,
        SEL_C      = 2'd2,
        SEL_MATRIX = 2'd3
    } t_sel;

    typedef struct packed {
        logic               valid;
        t_op                op;
        t_sel               sel;
        logic [IDX_W-1:0]   idx;
        logic [ENTRY_W-1:0] value;
    } t_ctrl;

endpackage

>>> rtl/lsf_table_ram.sv
`timescale 1ns / 1ps
// ============================================================================
// lsf_table_ram
// One-write, two-read synchronous table memory with registered read data.
// ============================================================================
module lsf_table_ram
    import lsf_pkg::*;
#(
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [ENTRY_W-1:0]       i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr0,
    input  logic [$clog2(DEPTH)-1:0] i_raddr1,
    output logic [ENTRY_W-1:0]       o_rdata0,
    output logic [ENTRY_W-1:0]       o_rdata1
);

    logic [ENTRY_W-1:0] r_mem [DEPTH];
    logic [ENTRY_W-1:0] r_rdata0;
    logic [ENTRY_W-1:0] r_rdata1;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata0 <= r_mem[i_raddr0];
        r_rdata1 <= r_mem[i_raddr1];
    end

    assign o_rdata0 = r_rdata0;
    assign o_rdata1 = r_rdata1;

endmodule

>>> rtl/lsf_project.sv
`timescale 1ns / 1ps
// ============================================================================
// lsf_project
// Axis matrix and the projection pipe: nine products, three row sums, then
// the fraction of each magnitude split into table index, next index, weight.
// ============================================================================
module lsf_project
    import lsf_pkg::*;
#(
    parameter int TABLE_ENTRIES = 4096
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic                                          i_mat_we,
    input  logic [MAT_IDX_W-1:0]                          i_mat_idx,
    input  logic [Q_W-1:0]                                i_mat_data,
    input  t_ctrl                                         i_ctrl,
    input  logic signed [Q_W-1:0]                         i_q_u,
    input  logic signed [Q_W-1:0]                         i_q_v,
    input  logic signed [Q_W-1:0]                         i_q_w,
    output t_ctrl                                         o_ctrl,
    output logic [AXES-1:0][$clog2(TABLE_ENTRIES)-1:0]    o_index,
    output logic [AXES-1:0][$clog2(TABLE_ENTRIES)-1:0]    o_next,
    output logic [AXES-1:0][WEIGHT_W-1:0]                 o_weight
);

    localparam int ADDR_W = $clog2(TABLE_ENTRIES);

    logic signed [Q_W-1:0]    r_matrix [MATRIX_COEFFS];
    logic signed [Q_W-1:0]    w_q      [AXES];
    logic signed [PROD_W-1:0] r_prod   [MATRIX_COEFFS];
    logic signed [SUM_W-1:0]  r_sum    [AXES];
    logic [AXES-1:0][ADDR_W-1:0]   r_index;
    logic [AXES-1:0][ADDR_W-1:0]   r_next;
    logic [AXES-1:0][WEIGHT_W-1:0] r_weight;
    t_ctrl r_ctrl1;
    t_ctrl r_ctrl2;
    t_ctrl r_ctrl3;

    assign w_q[0] = i_q_u;
    assign w_q[1] = i_q_v;
    assign w_q[2] = i_q_w;

    always_ff @(posedge i_clk) begin
        if (i_mat_we) begin
            r_matrix[i_mat_idx] <= $signed(i_mat_data);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl1 <= '0;
            r_ctrl2 <= '0;
            r_ctrl3 <= '0;
        end else begin
            r_ctrl1 <= i_ctrl;
            r_ctrl2 <= r_ctrl1;
            r_ctrl3 <= r_ctrl2;
        end
    end

    for (genvar gr = 0; gr < AXES; gr++) begin : g_row
        logic signed [SUM_W-1:0]  n_sum;
        logic [FRAC_W-1:0]        w_lo;
        logic [FRAC_W-1:0]        w_frac;
        logic [ADDR_W-1:0]        n_index;

        for (genvar gk = 0; gk < AXES; gk++) begin : g_col
            always_ff @(posedge i_clk) begin
                r_prod[gr*AXES+gk] <= r_matrix[gr*AXES+gk] * w_q[gk];
            end
        end

        assign n_sum = SUM_W'(r_prod[gr*AXES]) + SUM_W'(r_prod[gr*AXES+1])
                     + SUM_W'(r_prod[gr*AXES+2]);

        // fraction of the magnitude: negate the low bits of a negative sum
        assign w_lo    = r_sum[gr][FRAC_W-1:0];
        assign w_frac  = r_sum[gr][SUM_W-1] ? (FRAC_W'(0) - w_lo) : w_lo;
        assign n_index = w_frac[FRAC_W-1 -: ADDR_W];

        always_ff @(posedge i_clk) begin
            r_sum[gr]    <= n_sum;
            r_index[gr]  <= n_index;
            r_next[gr]   <= n_index + ADDR_W'(1);
            r_weight[gr] <= w_frac[FRAC_W-1-ADDR_W -: WEIGHT_W];
        end
    end

    assign o_ctrl   = r_ctrl3;
    assign o_index  = r_index;
    assign o_next   = r_next;
    assign o_weight = r_weight;

endmodule

>>> rtl/lsf_interp.sv
`timescale 1ns / 1ps
// ============================================================================
// lsf_interp
// Linear interpolation between two adjacent table entries, registered.
// ============================================================================
module lsf_interp
    import lsf_pkg::*;
(
    input  logic                i_clk,
    input  logic [ENTRY_W-1:0]  i_row0,
    input  logic [ENTRY_W-1:0]  i_row1,
    input  logic [WEIGHT_W-1:0] i_weight,
    output logic [ENTRY_W-1:0]  o_factor
);

    localparam int DIFF_W = ENTRY_W + 1;
    localparam int MUL_W  = DIFF_W + WEIGHT_W + 1;
    localparam int CORR_W = MUL_W - WEIGHT_W;

    logic signed [DIFF_W-1:0] w_diff;
    logic signed [MUL_W-1:0]  w_prod;
    logic signed [CORR_W-1:0] w_corr;
    logic signed [CORR_W-1:0] n_sum;
    logic [ENTRY_W-1:0]       r_factor;

    // (1-f)*v0 + f*v1 rewritten as v0 + f*(v1-v0), floor kept by the arithmetic shift
    assign w_diff = $signed({1'b0, i_row1}) - $signed({1'b0, i_row0});
    assign w_prod = $signed({1'b0, i_weight}) * w_diff;
    assign w_corr = $signed(w_prod[MUL_W-1:WEIGHT_W]);
    assign n_sum  = $signed({2'b00, i_row0}) + w_corr;

    always_ff @(posedge i_clk) begin
        r_factor <= n_sum[ENTRY_W-1:0];
    end

    assign o_factor = r_factor;

endmodule

>>> rtl/lsf_out_fifo.sv
`timescale 1ns / 1ps
// ============================================================================
// lsf_out_fifo
// Result queue between the pipe and the output channel.
// ============================================================================
module lsf_out_fifo
    import lsf_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  logic [RESULT_W-1:0]        i_data,
    input  logic                       i_pop,
    output logic                       o_valid,
    output logic [RESULT_W-1:0]        o_data,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [RESULT_W-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0]    r_wr_ptr;
    logic [PTR_W-1:0]    r_rd_ptr;
    logic [CNT_W-1:0]    r_count;
    logic [CNT_W-1:0]    n_count;
    logic                w_pop;

    assign w_pop   = i_pop && (r_count != '0);
    assign n_count = r_count + CNT_W'(i_push) - CNT_W'(w_pop);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            r_count <= n_count;
        end
    end

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign o_count = r_count;

endmodule

>>> rtl/lattice_shape_factor_lut.sv
`timescale 1ns / 1ps
// ============================================================================
// lattice_shape_factor_lut
// Lattice shape factor from three interpolated kernel tables and an axis matrix.
// ============================================================================
// The block takes one item per clock while o_stall is low. A load item writes
// a 24-bit table entry (axis a, b or c) or one of the nine Q8.24 axis matrix
// coefficients, and gives no result; out-of-range indexes are dropped. An
// evaluate item gives one Q30.34 result after a product stage, a row sum, the
// fraction split, the table read (each table has two read ports, so index and
// index+1 come in one access), interpolation, and two product stages. Loads
// write the tables in the same stage where evaluates read them, so an evaluate
// always sees every earlier load and no forwarding is needed. Results queue in
// a 16-entry output buffer; o_stall is high only while the buffer plus
// evaluates in flight hold 16, so with the output taking every cycle the block
// runs at one item per clock. TABLE_ENTRIES must be a power of two from 256 to
// 65536. Tables and matrix are not cleared at reset and must be written before
// they are read.
module lattice_shape_factor_lut
    import lsf_pkg::*;
#(
    parameter int TABLE_ENTRIES = 4096
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic                  i_operation,
    input  logic [1:0]            i_table_select,
    input  logic [IDX_W-1:0]      i_entry_index,
    input  logic signed [Q_W-1:0] i_entry_value,
    input  logic signed [Q_W-1:0] i_q_u,
    input  logic signed [Q_W-1:0] i_q_v,
    input  logic signed [Q_W-1:0] i_q_w,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [RESULT_W-1:0]   o_lattice_value
);

    localparam int ADDR_W = $clog2(TABLE_ENTRIES);
    localparam int CNT_W  = $clog2(OUT_FIFO_DEPTH + 1);
    localparam int AB_W   = 2 * ENTRY_W;
    localparam int FULL_W = AB_W + ENTRY_W;

    logic                  w_accept;
    logic                  w_accept_eval;
    logic                  w_mat_we;
    t_ctrl                 n_ctrl0;
    t_ctrl                 r_ctrl0;
    logic signed [Q_W-1:0] r_q_u;
    logic signed [Q_W-1:0] r_q_v;
    logic signed [Q_W-1:0] r_q_w;

    t_ctrl                         w_ctrl3;
    logic [AXES-1:0][ADDR_W-1:0]   w_index;
    logic [AXES-1:0][ADDR_W-1:0]   w_next;
    logic [AXES-1:0][WEIGHT_W-1:0] w_weight;
    logic [IDX_EXT_W-1:0]          w_idx_ext;
    logic                          w_in_range;
    logic                          w_eval3;

    logic [AXES-1:0][ENTRY_W-1:0]  w_rd0;
    logic [AXES-1:0][ENTRY_W-1:0]  w_rd1;
    logic [AXES-1:0][WEIGHT_W-1:0] r_weight4;
    logic [AXES-1:0][ENTRY_W-1:0]  w_factor;
    logic                          r_v4;
    logic                          r_v5;
    logic                          r_v6;
    logic                          r_v7;

    logic [AB_W-1:0]     n_ab;
    logic [AB_W-1:0]     r_ab;
    logic [ENTRY_W-1:0]  r_fc6;
    logic [AB_W-1:0]     r_p_hi;
    logic [AB_W-1:0]     r_p_lo;
    logic [FULL_W-1:0]   w_full;
    logic [RESULT_W-1:0] w_result;

    logic [CNT_W-1:0]    r_inflight;
    logic [CNT_W-1:0]    n_inflight;
    logic [CNT_W-1:0]    w_count;
    logic                w_pop;

    // ---------------- accept and stage 0 ----------------
    assign w_accept      = i_valid && !o_stall;
    assign w_accept_eval = w_accept && (t_op'(i_operation) == OP_EVAL);
    assign w_mat_we      = w_accept && (t_op'(i_operation) == OP_LOAD)
                         && (t_sel'(i_table_select) == SEL_MATRIX)
                         && (i_entry_index < IDX_W'(MATRIX_COEFFS));

    always_comb begin
        n_ctrl0.valid = w_accept;
        n_ctrl0.op    = t_op'(i_operation);
        n_ctrl0.sel   = t_sel'(i_table_select);
        n_ctrl0.idx   = i_entry_index;
        n_ctrl0.value = i_entry_value[ENTRY_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl0 <= '0;
        end else begin
            r_ctrl0 <= n_ctrl0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q_u <= i_q_u;
        r_q_v <= i_q_v;
        r_q_w <= i_q_w;
    end

    // ---------------- projection, stages 1 to 3 ----------------
    lsf_project #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_project (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_mat_we   (w_mat_we),
        .i_mat_idx  (i_entry_index[MAT_IDX_W-1:0]),
        .i_mat_data (i_entry_value),
        .i_ctrl     (r_ctrl0),
        .i_q_u      (r_q_u),
        .i_q_v      (r_q_v),
        .i_q_w      (r_q_w),
        .o_ctrl     (w_ctrl3),
        .o_index    (w_index),
        .o_next     (w_next),
        .o_weight   (w_weight)
    );

    // ---------------- table write and read ----------------
    assign w_idx_ext  = IDX_EXT_W'(w_ctrl3.idx);
    assign w_in_range = (w_idx_ext < IDX_EXT_W'(TABLE_ENTRIES));
    assign w_eval3    = w_ctrl3.valid && (w_ctrl3.op == OP_EVAL);

    for (genvar ga = 0; ga < AXES; ga++) begin : g_axis
        logic w_we;

        assign w_we = w_ctrl3.valid && (w_ctrl3.op == OP_LOAD) && w_in_range
                    && (w_ctrl3.sel == t_sel'(ga));

        lsf_table_ram #(
            .DEPTH (TABLE_ENTRIES)
        ) u_table (
            .i_clk    (i_clk),
            .i_we     (w_we),
            .i_waddr  (w_idx_ext[ADDR_W-1:0]),
            .i_wdata  (w_ctrl3.value),
            .i_raddr0 (w_index[ga]),
            .i_raddr1 (w_next[ga]),
            .o_rdata0 (w_rd0[ga]),
            .o_rdata1 (w_rd1[ga])
        );

        lsf_interp u_interp (
            .i_clk    (i_clk),
            .i_row0   (w_rd0[ga]),
            .i_row1   (w_rd1[ga]),
            .i_weight (r_weight4[ga]),
            .o_factor (w_factor[ga])
        );
    end

    always_ff @(posedge i_clk) begin
        r_weight4 <= w_weight;
    end

    // ---------------- product of the three factors ----------------
    assign n_ab = AB_W'(w_factor[0]) * AB_W'(w_factor[1]);

    always_ff @(posedge i_clk) begin
        r_ab   <= n_ab;
        r_fc6  <= w_factor[2];
        r_p_hi <= AB_W'(r_ab[AB_W-1:ENTRY_W]) * AB_W'(r_fc6);
        r_p_lo <= AB_W'(r_ab[ENTRY_W-1:0]) * AB_W'(r_fc6);
    end

    assign w_full   = {r_p_hi, ENTRY_W'(0)} + FULL_W'(r_p_lo);
    assign w_result = w_full[FULL_W-1 -: RESULT_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
            r_v7 <= 1'b0;
        end else begin
            r_v4 <= w_eval3;
            r_v5 <= r_v4;
            r_v6 <= r_v5;
            r_v7 <= r_v6;
        end
    end

    // ---------------- output queue and credit ----------------
    assign w_pop = o_valid && !i_stall;

    lsf_out_fifo #(
        .DEPTH (OUT_FIFO_DEPTH)
    ) u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_v7),
        .i_data  (w_result),
        .i_pop   (w_pop),
        .o_valid (o_valid),
        .o_data  (o_lattice_value),
        .o_count (w_count)
    );

    // evaluates in the pipe hold a queue slot from accept until push
    assign n_inflight = r_inflight + CNT_W'(w_accept_eval) - CNT_W'(r_v7);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= '0;
        end else begin
            r_inflight <= n_inflight;
        end
    end

    assign o_stall = (({1'b0, r_inflight} + {1'b0, w_count})
                     >= (CNT_W + 1)'(OUT_FIFO_DEPTH));

endmodule
